[hw/rtl/urc_pkg.sv]
package urc_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_DATA_W = 25;
  localparam int unsigned CFG_IDX_W  = 3;

  // Register field widths.
  localparam int unsigned TRIG_W   = 16;
  localparam int unsigned PERIOD_W = 25;

  // Counter and register values are compared at this common width.
  localparam int unsigned CMP_W = 32;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP  = 3'd4;

  // Register reset values.
  localparam logic [TRIG_W-1:0]   TRIGGER_RST  = 16'd800;
  localparam logic [PERIOD_W-1:0] PERIOD_RST   = 25'd2400000;
  localparam logic [PERIOD_W-1:0] COOLDOWN_RST = 25'd240000;
  localparam logic [PERIOD_W-1:0] TIMEOUT_RST  = 25'd24000000;
  localparam logic [PERIOD_W-1:0] STARTUP_RST  = 25'd16000000;

  typedef enum logic [2:0] {
    ST_STARTUP   = 3'd0,
    ST_TRIGGER   = 3'd1,
    ST_WAIT_ECHO = 3'd2,
    ST_ECHO_HIGH = 3'd3,
    ST_COOLDOWN  = 3'd4
  } stage_e;

  typedef struct packed {
    logic [TRIG_W-1:0]   trigger_ticks;
    logic [PERIOD_W-1:0] sample_period_ticks;
    logic [PERIOD_W-1:0] cooldown_ticks;
    logic [PERIOD_W-1:0] timeout_ticks;
    logic [PERIOD_W-1:0] startup_ticks;
  } cfg_t;

endpackage

[hw/rtl/urc_in_if.sv]
interface urc_in_if;
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink (input valid, input echo_level, output ready);
endinterface

[hw/rtl/urc_out_if.sv]
interface urc_out_if #(
  parameter int unsigned MEAS_WIDTH = 24
);
  logic                  valid;
  logic                  ready;
  logic                  trigger_active;
  logic                  meas_valid;
  logic [MEAS_WIDTH-1:0] meas_ticks;

  modport source (output valid, output trigger_active, output meas_valid,
                  output meas_ticks, input ready);
  modport sink (input valid, input trigger_active, input meas_valid,
                input meas_ticks, output ready);
endinterface

[hw/rtl/urc_cfg_regs.sv]
module urc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [urc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [urc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output urc_pkg::cfg_t                  cfg_o
);

  urc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_ticks       <= urc_pkg::TRIGGER_RST;
      cfg_q.sample_period_ticks <= urc_pkg::PERIOD_RST;
      cfg_q.cooldown_ticks      <= urc_pkg::COOLDOWN_RST;
      cfg_q.timeout_ticks       <= urc_pkg::TIMEOUT_RST;
      cfg_q.startup_ticks       <= urc_pkg::STARTUP_RST;
    end else if (cfg_we_i) begin
      // Writes to an unknown index are dropped.
      unique case (cfg_idx_i)
        urc_pkg::REG_TRIGGER: begin
          cfg_q.trigger_ticks <= cfg_data_i[urc_pkg::TRIG_W-1:0];
        end
        urc_pkg::REG_PERIOD:   cfg_q.sample_period_ticks <= cfg_data_i;
        urc_pkg::REG_COOLDOWN: cfg_q.cooldown_ticks      <= cfg_data_i;
        urc_pkg::REG_TIMEOUT:  cfg_q.timeout_ticks       <= cfg_data_i;
        urc_pkg::REG_STARTUP:  cfg_q.startup_ticks       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/urc_step.sv]
module urc_step #(
  parameter int unsigned MEAS_WIDTH  = 24,
  parameter int unsigned COUNT_WIDTH = 25
) (
  input  urc_pkg::cfg_t           cfg_i,
  input  logic                    echo_i,
  input  urc_pkg::stage_e         stage_i,
  input  logic [COUNT_WIDTH-1:0]  since_i,
  input  logic [COUNT_WIDTH-1:0]  phase_i,
  input  logic                    half_i,
  input  logic [MEAS_WIDTH-1:0]   width_i,
  input  logic [MEAS_WIDTH-1:0]   pub_i,
  output urc_pkg::stage_e         stage_o,
  output logic [COUNT_WIDTH-1:0]  since_o,
  output logic [COUNT_WIDTH-1:0]  phase_o,
  output logic                    half_o,
  output logic [MEAS_WIDTH-1:0]   width_o,
  output logic [MEAS_WIDTH-1:0]   pub_o,
  output logic                    meas_valid_o
);

  logic [COUNT_WIDTH-1:0] since_inc;
  logic [COUNT_WIDTH-1:0] phase_inc;
  logic                   start_trig;
  logic                   done;

  // Saturating increments.
  assign since_inc = (since_i == '1) ? since_i : since_i + COUNT_WIDTH'(1);
  assign phase_inc = (phase_i == '1) ? phase_i : phase_i + COUNT_WIDTH'(1);

  always_comb begin
    stage_o      = stage_i;
    since_o      = since_i;
    phase_o      = phase_i;
    half_o       = half_i;
    width_o      = width_i;
    pub_o        = pub_i;
    meas_valid_o = 1'b0;
    start_trig   = 1'b0;
    done         = 1'b0;

    unique case (stage_i) inside
      urc_pkg::ST_STARTUP: begin
        if (urc_pkg::CMP_W'(phase_i) >= urc_pkg::CMP_W'(cfg_i.startup_ticks)) begin
          start_trig = 1'b1;
        end else begin
          phase_o = phase_inc;
        end
      end
      urc_pkg::ST_TRIGGER, urc_pkg::ST_WAIT_ECHO, urc_pkg::ST_ECHO_HIGH,
      urc_pkg::ST_COOLDOWN: begin
        since_o = since_inc;
        if (urc_pkg::CMP_W'(since_inc) >=
            urc_pkg::CMP_W'(cfg_i.sample_period_ticks)) begin
          half_o = 1'b1;
        end
        unique case (stage_i)
          urc_pkg::ST_TRIGGER: begin
            phase_o = phase_inc;
            if (urc_pkg::CMP_W'(phase_inc) >= urc_pkg::CMP_W'(cfg_i.trigger_ticks)) begin
              stage_o = urc_pkg::ST_WAIT_ECHO;
            end
          end
          urc_pkg::ST_WAIT_ECHO: begin
            if (echo_i) begin
              stage_o = urc_pkg::ST_ECHO_HIGH;
              width_o = MEAS_WIDTH'(1);
            end
          end
          urc_pkg::ST_ECHO_HIGH: begin
            if (echo_i) begin
              width_o = width_i + MEAS_WIDTH'(1);
            end else begin
              stage_o = urc_pkg::ST_COOLDOWN;
              phase_o = '0;
            end
          end
          default: begin
            phase_o = phase_inc;
            if (urc_pkg::CMP_W'(phase_inc) >= urc_pkg::CMP_W'(cfg_i.cooldown_ticks) &&
                half_o) begin
              pub_o        = width_i;
              meas_valid_o = 1'b1;
              done         = 1'b1;
              start_trig   = 1'b1;
            end
          end
        endcase
        // A completion on the same tick takes precedence over the timeout.
        if (!done &&
            urc_pkg::CMP_W'(since_inc) >= urc_pkg::CMP_W'(cfg_i.timeout_ticks)) begin
          start_trig = 1'b1;
        end
      end
      default: start_trig = 1'b1;
    endcase

    if (start_trig) begin
      stage_o = urc_pkg::ST_TRIGGER;
      since_o = '0;
      phase_o = '0;
      half_o  = 1'b0;
      width_o = '0;
    end
  end

endmodule

[hw/rtl/ultrasonic_ranger_controller.sv]
// Ultrasonic ranger controller. Every input item is one timebase tick with the
// sampled echo pin level, and every accepted item yields exactly one result
// item carrying the trigger drive level, a one-tick publish strobe and the last
// published echo width in ticks (modulo 2^MEAS_WIDTH, zero until the first
// measurement). After reset the block waits startup_ticks, drives the trigger
// for trigger_ticks, measures the echo high time, and publishes it and
// retriggers once sample_period_ticks have passed since the trigger began and
// cooldown_ticks have passed since the echo fell; if timeout_ticks pass first,
// it retriggers silently. The block takes one item per clock cycle as long as
// the output is not stalled: the tick is folded into the state registers and
// the result register at the same edge, so the result register is the only
// stage. Input is accepted whenever the result register is empty or being
// drained. Configuration is written through a plain write port and should
// only be changed while no items are in flight.
module ultrasonic_ranger_controller #(
  parameter int unsigned MEAS_WIDTH  = 24,
  parameter int unsigned COUNT_WIDTH = 25
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [urc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [urc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  urc_in_if.sink                         in_i,
  urc_out_if.source                      out_o
);

  urc_pkg::cfg_t cfg;

  // Measurement state, advanced once per accepted item.
  urc_pkg::stage_e        stage_q, stage_d;
  logic [COUNT_WIDTH-1:0] since_q, since_d;
  logic [COUNT_WIDTH-1:0] phase_q, phase_d;
  logic                   half_q, half_d;
  logic [MEAS_WIDTH-1:0]  width_q, width_d;
  logic [MEAS_WIDTH-1:0]  pub_q, pub_d;
  logic                   meas_valid_d;

  // Result register.
  logic                  out_valid_q;
  logic                  trig_q;
  logic                  meas_valid_q;
  logic [MEAS_WIDTH-1:0] meas_ticks_q;

  logic in_acc;

  urc_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  urc_step #(
    .MEAS_WIDTH  (MEAS_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .cfg_i        (cfg),
    .echo_i       (in_i.echo_level),
    .stage_i      (stage_q),
    .since_i      (since_q),
    .phase_i      (phase_q),
    .half_i       (half_q),
    .width_i      (width_q),
    .pub_i        (pub_q),
    .stage_o      (stage_d),
    .since_o      (since_d),
    .phase_o      (phase_d),
    .half_o       (half_d),
    .width_o      (width_d),
    .pub_o        (pub_d),
    .meas_valid_o (meas_valid_d)
  );

  // The result register frees up in the same cycle it is read out.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q     <= urc_pkg::ST_STARTUP;
      since_q     <= '0;
      phase_q     <= '0;
      half_q      <= 1'b0;
      width_q     <= '0;
      pub_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        stage_q     <= stage_d;
        since_q     <= since_d;
        phase_q     <= phase_d;
        half_q      <= half_d;
        width_q     <= width_d;
        pub_q       <= pub_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      trig_q       <= (stage_d == urc_pkg::ST_TRIGGER);
      meas_valid_q <= meas_valid_d;
      meas_ticks_q <= pub_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.trigger_active = trig_q;
  assign out_o.meas_valid     = meas_valid_q;
  assign out_o.meas_ticks     = meas_ticks_q;

  // A publication always starts the next trigger on the same tick.
  a_pub_retriggers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && meas_valid_q |-> trig_q)
    else $error("measurement published without a new trigger");

  // Every accepted item leaves a result behind.
  a_acc_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted item produced no result");

  // During the startup wait no trigger has run yet.
  a_startup_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q == urc_pkg::ST_STARTUP |-> since_q == '0 && !half_q && width_q == '0)
    else $error("trigger state is dirty during startup");

  // The state only moves when an item is accepted.
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(stage_q) && $stable(since_q) && $stable(pub_q))
    else $error("state changed without an accepted item");

endmodule
